// File: sv/pfes_pkg.sv
// ----------------------------------------------------------------------------
// Potential-field escape steering: shared package
// Holds the widths, the sine table, the register indexes and the types that
// the front part, the queue and the back part exchange.
// ----------------------------------------------------------------------------
package pfes_pkg;

   localparam int TRIG_FRAC_BITS = 14;
   localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
   localparam int SINE_LAST      = 90;
   localparam int WEIGHT_W       = 24;
   localparam int PROD_W         = WEIGHT_W + TRIG_W;
   localparam int TERM_W         = PROD_W + 1;
   localparam int FORCE_W        = 56;
   localparam int QUEUE_DEPTH    = 4;
   localparam int REQ_DATA_W     = 48;
   localparam int RSP_DATA_W     = 136;
   localparam int CSR_DATA_W     = 6;

   localparam logic [63:0] DEG_Q30 = 64'd18740330;
   localparam int TAYLOR_DIV [1:6] = '{6, 20, 42, 72, 110, 156};

   localparam logic [5:0] POWER_RESET = 6'd25;
   localparam logic [5:0] POWER_MIN   = 6'd10;
   localparam logic [5:0] POWER_MAX   = 6'd50;
   localparam logic [6:0] TURN_LIMIT  = 7'd90;

   typedef enum logic [1:0] {
      CSR_STOPPED_ONLY  = 2'd0,
      CSR_SPIN_STEERING = 2'd1,
      CSR_DRIVE_POWER   = 2'd2
   } csr_index_type;

   typedef logic [TRIG_W-1:0] sine_tab_type [0:SINE_LAST];

   typedef struct packed {
      logic       stopped_only;
      logic       spin_steering;
      logic [5:0] drive_power;
   } cfg_type;

   typedef struct packed {
      logic                use_reading;
      logic                repel;
      logic [WEIGHT_W-1:0] weight;
      logic [TRIG_W-1:0]   cos_mag;
      logic                cos_neg;
      logic [TRIG_W-1:0]   sin_mag;
      logic                sin_neg;
      logic                last;
      logic                danger;
      logic                stopped;
      logic [6:0]          turn;
   } queue_entry_type;

   // Sine in whole degrees, Taylor series in Q30 rounded to the table format.
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  pos;
      logic [63:0]  neg;
      logic [63:0]  r;
      for (int d = 0; d <= SINE_LAST; d++) begin
         x    = 64'(d) * DEG_Q30;
         x2   = (x * x) >> 30;
         term = x;
         pos  = x;
         neg  = 64'd0;
         for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k]);
            if ((k & 1) != 0) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         r = pos - neg;
         r = (r + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
         tab[d] = TRIG_W'(r);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

// File: sv/pfes_front.sv
// ----------------------------------------------------------------------------
// Potential-field escape steering: front part
// Classifies one reading: folds the beam angle onto the sine table for both
// components, forms the distance error and the attractive or repulsive
// weight, and passes the scan-end flags along.
// ----------------------------------------------------------------------------
module pfes_front
   import pfes_pkg::*;
(
   input  logic signed [8:0]  beam_angle,
   input  logic signed [13:0] range_mm,
   input  logic [11:0]        zone_limit_mm,
   input  logic               scan_end,
   input  logic               zone_entered,
   input  logic               robot_stopped,
   input  logic [6:0]         turn_amount,
   output queue_entry_type    entry
);

   typedef struct packed {
      logic       neg;
      logic [6:0] idx;
   } trig_ref_type;

   function automatic trig_ref_type fold(logic [8:0] n);
      trig_ref_type t;
      t.neg = 1'b0;
      if (n <= 9'd90) begin
         t.idx = n[6:0];
      end else if (n <= 9'd180) begin
         t.idx = 7'(9'd180 - n);
      end else if (n <= 9'd270) begin
         t.idx = 7'(n - 9'd180);
         t.neg = 1'b1;
      end else begin
         t.idx = 7'(9'd360 - n);
         t.neg = 1'b1;
      end
      return t;
   endfunction

   logic [9:0]   angle_ext;
   logic [9:0]   cos_raw;
   logic [8:0]   sin_n;
   logic [8:0]   cos_n;
   trig_ref_type sin_ref;
   trig_ref_type cos_ref;
   logic [14:0]  err;
   logic [11:0]  err_abs;

   always_comb begin
      angle_ext = {beam_angle[8], beam_angle};
      sin_n     = 9'(angle_ext + (beam_angle[8] ? 10'd360 : 10'd0));
      cos_raw   = angle_ext + 10'd90;
      cos_n     = 9'(cos_raw + (cos_raw[9] ? 10'd360 : 10'd0));
      sin_ref   = fold(sin_n);
      cos_ref   = fold(cos_n);

      err     = {range_mm[13], range_mm} - {3'b000, zone_limit_mm};
      err_abs = 12'(15'd0 - err);

      entry.use_reading = ~range_mm[13];
      entry.repel       = err[14];
      entry.weight      = err[14] ? WEIGHT_W'(err_abs) * WEIGHT_W'(err_abs)
                                  : WEIGHT_W'(err[12:0]);
      entry.cos_mag     = SINE_TAB[cos_ref.idx];
      entry.cos_neg     = cos_ref.neg;
      entry.sin_mag     = SINE_TAB[sin_ref.idx];
      entry.sin_neg     = sin_ref.neg;
      entry.last        = scan_end;
      entry.danger      = zone_entered;
      entry.stopped     = robot_stopped;
      entry.turn        = turn_amount;
   end

endmodule

// File: sv/pfes_queue.sv
// ----------------------------------------------------------------------------
// Potential-field escape steering: classified-reading queue
// A short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module pfes_queue
   import pfes_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type pop_entry,
   output logic            full,
   output logic            not_empty
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;

   assign full      = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + COUNT_W'(push) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: sv/pfes_back.sv
// ----------------------------------------------------------------------------
// Potential-field escape steering: back part
// Multiplies each weight by its sine and cosine, adds the vector into the
// attractive or repulsive sums with saturation, and at the end of a scan
// decides on extrication, loads the result register and clears the sums.
// ----------------------------------------------------------------------------
module pfes_back
   import pfes_pkg::*;
#(
   parameter int ACC_BITS = 56
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  queue_entry_type       q_entry,
   input  logic                  q_valid,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

   function automatic logic signed [ACC_BITS-1:0] sat_add(
      logic signed [ACC_BITS-1:0] a,
      logic signed [ACC_BITS-1:0] b
   );
      logic [ACC_BITS:0] s;
      s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
      if (s[ACC_BITS] != s[ACC_BITS-1]) begin
         return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_BITS-1:0];
   endfunction

   function automatic logic signed [ACC_BITS-1:0] sat_sub(
      logic signed [ACC_BITS-1:0] a,
      logic signed [ACC_BITS-1:0] b
   );
      logic [ACC_BITS:0] s;
      s = {a[ACC_BITS-1], a} - {b[ACC_BITS-1], b};
      if (s[ACC_BITS] != s[ACC_BITS-1]) begin
         return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_BITS-1:0];
   endfunction

   function automatic logic signed [TERM_W-1:0] signed_term(
      logic [PROD_W-1:0] mag,
      logic              neg
   );
      logic [TERM_W-1:0] t;
      t = {1'b0, mag};
      return neg ? TERM_W'(~t + 1'b1) : t;
   endfunction

   // Product stage
   logic                     p_valid_ff;
   logic                     p_use_ff;
   logic                     p_repel_ff;
   logic                     p_last_ff;
   logic                     p_danger_ff;
   logic                     p_stopped_ff;
   logic [6:0]               p_turn_ff;
   logic signed [TERM_W-1:0] p_x_ff;
   logic signed [TERM_W-1:0] p_y_ff;
   logic [PROD_W-1:0]        prod_x;
   logic [PROD_W-1:0]        prod_y;

   // Sums
   logic signed [ACC_BITS-1:0] attract_x_ff;
   logic signed [ACC_BITS-1:0] attract_y_ff;
   logic signed [ACC_BITS-1:0] repel_x_ff;
   logic signed [ACC_BITS-1:0] repel_y_ff;
   logic signed [ACC_BITS-1:0] attract_x_in;
   logic signed [ACC_BITS-1:0] attract_y_in;
   logic signed [ACC_BITS-1:0] repel_x_in;
   logic signed [ACC_BITS-1:0] repel_y_in;
   logic signed [ACC_BITS-1:0] term_x;
   logic signed [ACC_BITS-1:0] term_y;

   // Decision stage
   logic       d_pending_ff;
   logic       d_pending_in;
   logic       d_danger_ff;
   logic       d_stopped_ff;
   logic [6:0] d_turn_ff;
   logic       decide;

   logic signed [ACC_BITS-1:0] fx;
   logic signed [ACC_BITS-1:0] fy;
   logic                       acted;
   logic                       x_zero;
   logic                       x_neg;
   logic                       x_pos;
   logic                       y_zero;
   logic                       y_neg;
   logic                       y_pos;
   logic                       fwd;
   logic                       turn_neg;
   logic [5:0]                 power_sat;
   logic [6:0]                 turn_sat;

   // Result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [1:0]            drive_dir;
   logic signed [7:0]     turn_deg;
   logic signed [6:0]     power_cmd;
   logic [FORCE_W-1:0]    force_x;
   logic [FORCE_W-1:0]    force_y;

   assign q_pop      = q_valid & ~(p_valid_ff & p_last_ff) & ~d_pending_ff;
   assign decide     = d_pending_ff & (~rsp_valid_ff | rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign prod_x = PROD_W'(q_entry.weight) * PROD_W'(q_entry.cos_mag);
   assign prod_y = PROD_W'(q_entry.weight) * PROD_W'(q_entry.sin_mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         p_use_ff     <= q_entry.use_reading;
         p_repel_ff   <= q_entry.repel;
         p_last_ff    <= q_entry.last;
         p_danger_ff  <= q_entry.danger;
         p_stopped_ff <= q_entry.stopped;
         p_turn_ff    <= q_entry.turn;
         p_x_ff       <= signed_term(prod_x, q_entry.cos_neg);
         p_y_ff       <= signed_term(prod_y, q_entry.sin_neg);
      end
   end

   always_comb begin
      term_x       = ACC_BITS'(p_x_ff);
      term_y       = ACC_BITS'(p_y_ff);
      attract_x_in = attract_x_ff;
      attract_y_in = attract_y_ff;
      repel_x_in   = repel_x_ff;
      repel_y_in   = repel_y_ff;
      if (decide) begin
         attract_x_in = '0;
         attract_y_in = '0;
         repel_x_in   = '0;
         repel_y_in   = '0;
      end else if (p_valid_ff && p_use_ff) begin
         if (p_repel_ff) begin
            repel_x_in = sat_add(repel_x_ff, term_x);
            repel_y_in = sat_add(repel_y_ff, term_y);
         end else begin
            attract_x_in = sat_add(attract_x_ff, term_x);
            attract_y_in = sat_add(attract_y_ff, term_y);
         end
      end
      d_pending_in = d_pending_ff;
      if (decide) begin
         d_pending_in = 1'b0;
      end else if (p_valid_ff && p_last_ff) begin
         d_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attract_x_ff <= '0;
         attract_y_ff <= '0;
         repel_x_ff   <= '0;
         repel_y_ff   <= '0;
         d_pending_ff <= 1'b0;
      end else begin
         attract_x_ff <= attract_x_in;
         attract_y_ff <= attract_y_in;
         repel_x_ff   <= repel_x_in;
         repel_y_ff   <= repel_y_in;
         d_pending_ff <= d_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_valid_ff && p_last_ff) begin
         d_danger_ff  <= p_danger_ff;
         d_stopped_ff <= p_stopped_ff;
         d_turn_ff    <= p_turn_ff;
      end
   end

   always_comb begin
      fx     = sat_sub(attract_x_ff, repel_x_ff);
      fy     = sat_sub(attract_y_ff, repel_y_ff);
      acted  = d_danger_ff & (~cfg.stopped_only | d_stopped_ff);
      x_zero = (fx == '0);
      x_neg  = fx[ACC_BITS-1];
      x_pos  = ~x_neg & ~x_zero;
      y_zero = (fy == '0);
      y_neg  = fy[ACC_BITS-1];
      y_pos  = ~y_neg & ~y_zero;

      if ((x_pos && !y_neg) || (x_zero && y_zero)) begin
         fwd      = 1'b1;
         turn_neg = 1'b0;
      end else if (!x_pos && y_pos) begin
         fwd      = 1'b0;
         turn_neg = 1'b1;
      end else if (x_neg && !y_pos) begin
         fwd      = 1'b0;
         turn_neg = 1'b0;
      end else begin
         fwd      = 1'b1;
         turn_neg = 1'b1;
      end

      if (cfg.drive_power < POWER_MIN) begin
         power_sat = POWER_MIN;
      end else if (cfg.drive_power > POWER_MAX) begin
         power_sat = POWER_MAX;
      end else begin
         power_sat = cfg.drive_power;
      end
      turn_sat = (d_turn_ff > TURN_LIMIT) ? TURN_LIMIT : d_turn_ff;

      if (acted) begin
         drive_dir = fwd ? 2'b01 : 2'b11;
         turn_deg  = turn_neg ? 8'(~{1'b0, turn_sat} + 1'b1) : {1'b0, turn_sat};
         if (cfg.spin_steering) begin
            power_cmd = '0;
         end else begin
            power_cmd = fwd ? {1'b0, power_sat} : 7'(~{1'b0, power_sat} + 1'b1);
         end
         force_x = FORCE_W'(fx);
         force_y = FORCE_W'(fy);
      end else begin
         drive_dir = '0;
         turn_deg  = '0;
         power_cmd = '0;
         force_x   = '0;
         force_y   = '0;
      end

      rsp_data_in = RSP_DATA_W'({force_y, force_x, power_cmd, turn_deg, drive_dir, acted});

      if (decide) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (decide) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: sv/potential_field_escape_steering.sv
// ----------------------------------------------------------------------------
// Potential-field escape steering
// Sums laser readings into attractive and repulsive force vectors and, at the
// end of each scan, issues an extrication drive and turn command.
//
//   Channel  Direction  Handshake                Payload
//   req      in         req_tvalid / req_tready  req_tdata, req_tlast
//   rsp      out        rsp_tvalid / rsp_tready  rsp_tdata
//   csr      in         csr_wr_en                csr_index, csr_wdata
//
// Readings that do not end a scan are taken one per cycle while the queue has
// room. A scan-end reading keeps the back part busy through its product, sum
// and decision steps, and its result is offered once the decision step loads the result register.
// Reset clears the sums and the queue and sets the registers to their defaults.
// The input stalls only when the four-entry queue is full; a stalled result
// holds the decision, and the queue keeps filling behind it.
// ----------------------------------------------------------------------------
module potential_field_escape_steering
   import pfes_pkg::*;
#(
   parameter int ACC_BITS = 56
) (
   input  logic                  clock,
   input  logic                  reset,
   // beam_angle, range_mm, zone_limit_mm, zone_entered, robot_stopped,
   // turn_amount, from the lowest bit up
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // acted, drive_dir, turn_deg, power_cmd, force_x, force_y,
   // from the lowest bit up
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   queue_entry_type front_entry;
   queue_entry_type back_entry;
   logic            queue_full;
   logic            queue_not_empty;
   logic            queue_pop;
   logic            req_push;

   assign req_tready = ~queue_full;
   assign req_push   = req_tvalid & ~queue_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_STOPPED_ONLY:  cfg_in.stopped_only  = csr_wdata[0];
            CSR_SPIN_STEERING: cfg_in.spin_steering = csr_wdata[0];
            CSR_DRIVE_POWER:   cfg_in.drive_power   = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stopped_only  <= 1'b0;
         cfg_ff.spin_steering <= 1'b0;
         cfg_ff.drive_power   <= POWER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfes_front u_front (
      .beam_angle    (req_tdata[8:0]),
      .range_mm      (req_tdata[22:9]),
      .zone_limit_mm (req_tdata[34:23]),
      .scan_end      (req_tlast),
      .zone_entered  (req_tdata[35]),
      .robot_stopped (req_tdata[36]),
      .turn_amount   (req_tdata[43:37]),
      .entry         (front_entry)
   );

   pfes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_entry (front_entry),
      .pop        (queue_pop),
      .pop_entry  (back_entry),
      .full       (queue_full),
      .not_empty  (queue_not_empty)
   );

   pfes_back #(
      .ACC_BITS (ACC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_entry    (back_entry),
      .q_valid    (queue_not_empty),
      .q_pop      (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/escape_command_checker.sv
// ----------------------------------------------------------------------------
// Escape steering command checker
// Watches the reading, command and register ports of the steering block. It
// keeps its own force sums, sine table and register copies, forms the
// expected command for every scan-end reading and compares each command
// transaction with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module escape_command_checker
   import pfes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    pending_commands,
   output int                    extrications
);

   localparam longint ACC_MAX = (64'sd1 <<< (FORCE_W - 1)) - 64'sd1;
   localparam longint ACC_MIN = -ACC_MAX - 64'sd1;
   localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;

   typedef struct packed {
      logic signed [FORCE_W-1:0] force_y;
      logic signed [FORCE_W-1:0] force_x;
      logic signed [6:0]         power_cmd;
      logic signed [7:0]         turn_deg;
      logic signed [1:0]         drive_dir;
      logic                      acted;
   } escape_cmd_type;

   escape_cmd_type expected_commands[$];
   longint         sine_lut [0:90];
   longint         attract_x, attract_y, repel_x, repel_y;
   logic           restart_only_stopped;
   logic           spin_mode;
   logic [5:0]     power_level;
   int             decisions_seen;

   initial begin
      longint unsigned x, x2, term, pos, neg, r;
      for (int d = 0; d <= 90; d++) begin
         x    = 64'(d) * RAD_PER_DEG_Q30;
         x2   = (x * x) >> 30;
         term = x;
         pos  = x;
         neg  = 0;
         for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         r = pos - neg;
         r = (r + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
         sine_lut[d] = longint'(r);
      end
   end

   function automatic longint clamp_acc(input longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
   endfunction

   function automatic longint trig_deg(input int deg);
      int n;
      n = deg % 360;
      if (n < 0) n += 360;
      if (n <= 90) return sine_lut[n];
      if (n <= 180) return sine_lut[180 - n];
      if (n <= 270) return -sine_lut[n - 180];
      return -sine_lut[360 - n];
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("command %0d: %s is %0d, expected %0d", decisions_seen, what, got, want);
   endtask

   task automatic predict_escape(input logic [REQ_DATA_W-1:0] data, input logic last);
      int             angle, range_mm, limit, turn, pw, dir, tdeg;
      logic           danger, stopped;
      longint         err, c, s, fx, fy;
      escape_cmd_type cmd;
      angle    = $signed(data[8:0]);
      range_mm = $signed(data[22:9]);
      limit    = int'(data[34:23]);
      danger   = data[35];
      stopped  = data[36];
      turn     = int'(data[43:37]);
      if (range_mm >= 0) begin
         err = longint'(range_mm - limit);
         c   = trig_deg(angle + 90);
         s   = trig_deg(angle);
         if (err < 0) begin
            repel_x = clamp_acc(repel_x + err * err * c);
            repel_y = clamp_acc(repel_y + err * err * s);
         end else begin
            attract_x = clamp_acc(attract_x + err * c);
            attract_y = clamp_acc(attract_y + err * s);
         end
      end
      if (last) begin
         cmd = '0;
         if (danger && (!restart_only_stopped || stopped)) begin
            pw = int'(power_level);
            if (pw < int'(POWER_MIN)) pw = int'(POWER_MIN);
            if (pw > int'(POWER_MAX)) pw = int'(POWER_MAX);
            if (turn > int'(TURN_LIMIT)) turn = int'(TURN_LIMIT);
            fx = clamp_acc(attract_x - repel_x);
            fy = clamp_acc(attract_y - repel_y);
            if ((fx > 0 && fy >= 0) || (fx == 0 && fy == 0)) begin
               dir  = 1;
               tdeg = turn;
            end else if (fx <= 0 && fy > 0) begin
               dir  = -1;
               tdeg = -turn;
            end else if (fx < 0 && fy <= 0) begin
               dir  = -1;
               tdeg = turn;
            end else begin
               dir  = 1;
               tdeg = -turn;
            end
            cmd.acted     = 1'b1;
            cmd.drive_dir = 2'(dir);
            cmd.turn_deg  = 8'(tdeg);
            cmd.power_cmd = spin_mode ? 7'sd0 : 7'(dir * pw);
            cmd.force_x   = FORCE_W'(fx);
            cmd.force_y   = FORCE_W'(fy);
            extrications++;
         end
         attract_x = 0;
         attract_y = 0;
         repel_x   = 0;
         repel_y   = 0;
         expected_commands.push_back(cmd);
      end
   endtask

   always @(posedge clock) begin : observe
      escape_cmd_type got, want;
      if (reset) begin
         restart_only_stopped = 1'b0;
         spin_mode            = 1'b0;
         power_level          = POWER_RESET;
         attract_x            = 0;
         attract_y            = 0;
         repel_x              = 0;
         repel_y              = 0;
         expected_commands.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_STOPPED_ONLY: begin
                  restart_only_stopped = csr_wdata[0];
               end
               CSR_SPIN_STEERING: begin
                  spin_mode = csr_wdata[0];
               end
               CSR_DRIVE_POWER: begin
                  power_level = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = escape_cmd_type'(rsp_tdata[$bits(escape_cmd_type)-1:0]);
            decisions_seen++;
            if (expected_commands.size() == 0) begin
               report_mismatch("unexpected command, acted", longint'(got.acted), 0);
            end else begin
               want = expected_commands.pop_front();
               if (got.acted !== want.acted) begin
                  report_mismatch("acted", longint'(got.acted), longint'(want.acted));
               end
               if (got.drive_dir !== want.drive_dir) begin
                  report_mismatch("drive_dir", got.drive_dir, want.drive_dir);
               end
               if (got.turn_deg !== want.turn_deg) begin
                  report_mismatch("turn_deg", got.turn_deg, want.turn_deg);
               end
               if (got.power_cmd !== want.power_cmd) begin
                  report_mismatch("power_cmd", got.power_cmd, want.power_cmd);
               end
               if (got.force_x !== want.force_x) begin
                  report_mismatch("force_x", got.force_x, want.force_x);
               end
               if (got.force_y !== want.force_y) begin
                  report_mismatch("force_y", got.force_y, want.force_y);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_escape(req_tdata, req_tlast);
         end
      end
      pending_commands = expected_commands.size();
   end

endmodule

// File: tb/potential_field_escape_steering_test.sv
// ----------------------------------------------------------------------------
// Potential-field escape steering testbench
// Drives laser readings into the steering block, first a directed set of
// quadrant, saturation and bad-reading cases, then random scans under
// several register settings, with random idling on both channels and one
// long hold-off of the command channel. A checker beside the block predicts
// every command and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module potential_field_escape_steering_test;
   import pfes_pkg::*;

   localparam int QUIET_LIMIT = 3000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en  = 1'b0;
   logic [1:0]            csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int mismatches;
   int pending_commands;
   int extrications;
   int readings_sent;
   int scans_sent;
   int settings_used;

   always #10 clock = ~clock;

   potential_field_escape_steering dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   escape_command_checker command_check (
      .clock            (clock),
      .reset            (reset),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .pending_commands (pending_commands),
      .extrications     (extrications)
   );

   task automatic send_reading(input logic signed [8:0] angle, input logic signed [13:0] range_mm,
                               input logic [11:0] limit, input logic last, input logic danger,
                               input logic stopped, input logic [6:0] turn);
      while (!(readings_sent >= 600 && readings_sent < 750) && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {4'b0, turn, stopped, danger, limit, range_mm, angle};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      readings_sent++;
      if (last) scans_sent++;
      @(negedge clock);
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_commands != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic configure(input logic restart, input logic spin, input logic [5:0] power);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_STOPPED_ONLY;
      csr_wdata <= {5'b0, restart};
      @(negedge clock);
      csr_index <= CSR_SPIN_STEERING;
      csr_wdata <= {5'b0, spin};
      @(negedge clock);
      csr_index <= CSR_DRIVE_POWER;
      csr_wdata <= power;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random_phase(input int item_goal);
      int                start, len, r;
      logic signed [8:0] angle;
      logic signed [13:0] range_mm;
      logic [11:0]       limit;
      logic [6:0]        turn;
      logic              last, danger;
      start = readings_sent;
      while (readings_sent - start < item_goal) begin
         len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 16);
         for (int i = 0; i < len; i++) begin
            last  = (i == len - 1);
            angle = ($urandom_range(0, 99) < 85) ? 9'(int'($urandom_range(0, 360)) - 180)
                                                 : 9'($urandom_range(0, 511));
            limit = 12'($urandom_range(0, 4095));
            r     = $urandom_range(0, 99);
            if (r < 10) begin
               range_mm = 14'($urandom_range(8192, 16383));
            end else if (r < 30) begin
               r = int'(limit) + int'($urandom_range(0, 100)) - 50;
               if (r < 0) r = 0;
               range_mm = 14'(r);
            end else begin
               range_mm = 14'($urandom_range(0, 8191));
            end
            danger = last ? ($urandom_range(0, 99) < 75) : 1'($urandom_range(0, 1));
            turn   = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 90))
                                                  : 7'($urandom_range(0, 127));
            send_reading(angle, range_mm, limit, last, danger, 1'($urandom_range(0, 1)), turn);
         end
      end
   endtask

   initial begin : command_sink
      bit held_off;
      held_off = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && readings_sent >= 350) begin
            held_off = 1'b1;
            repeat (80) begin
               rsp_tready <= 1'b0;
               @(negedge clock);
            end
         end
         if (readings_sent >= 550 && readings_sent < 700) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 14);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("stalled for %0d cycles with %0d commands outstanding", QUIET_LIMIT,
               pending_commands);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: each axis direction, the zero force and the saturated turn.
      send_reading(9'sd0, 14'sd8191, 12'd0, 1'b1, 1'b1, 1'b0, 7'd45);
      send_reading(9'sd90, 14'sd5000, 12'd1000, 1'b1, 1'b1, 1'b0, 7'd90);
      send_reading(9'sd180, 14'sd3000, 12'd0, 1'b1, 1'b1, 1'b1, 7'd127);
      send_reading(-9'sd90, 14'sd100, 12'd0, 1'b1, 1'b1, 1'b0, 7'd0);
      send_reading(9'sd30, -14'sd1, 12'd0, 1'b1, 1'b1, 1'b0, 7'd60);
      send_reading(9'sd255, -14'sd8192, 12'd4095, 1'b1, 1'b0, 1'b1, 7'd127);
      send_reading(9'sd45, 14'sd0, 12'd4095, 1'b0, 1'b1, 1'b1, 7'd127);
      send_reading(-9'sd180, 14'sd10, 12'd4095, 1'b1, 1'b1, 1'b0, 7'd30);
      send_reading(-9'sd256, 14'sd8191, 12'd4095, 1'b0, 1'b0, 1'b0, 7'd0);
      send_reading(9'sd180, 14'sd4095, 12'd4095, 1'b0, 1'b1, 1'b1, 7'd90);
      send_reading(9'sd135, 14'sd2000, 12'd100, 1'b1, 1'b1, 1'b1, 7'd127);
      send_reading(-9'sd45, 14'sd8000, 12'd200, 1'b0, 1'b0, 1'b1, 7'd12);
      send_reading(9'sd10, 14'sd50, 12'd3000, 1'b1, 1'b1, 1'b0, 7'd89);
      send_reading(9'sd0, 14'sd0, 12'd0, 1'b1, 1'b0, 1'b1, 7'd0);
      send_reading(-9'sd135, 14'sd4000, 12'd4095, 1'b1, 1'b1, 1'b0, 7'd91);
      settle_block();

      // Restart mode waits for a stopped robot; drive power below range saturates.
      configure(1'b1, 1'b0, 6'd0);
      send_reading(9'sd60, 14'sd500, 12'd0, 1'b1, 1'b1, 1'b0, 7'd45);
      send_reading(9'sd60, 14'sd500, 12'd0, 1'b1, 1'b1, 1'b1, 7'd45);
      send_reading(-9'sd150, 14'sd20, 12'd2000, 1'b1, 1'b0, 1'b1, 7'd45);
      settle_block();

      configure(1'b0, 1'b1, 6'd63);
      send_reading(-9'sd120, 14'sd7000, 12'd0, 1'b1, 1'b1, 1'b0, 7'd70);
      settle_block();
      configure(1'b0, 1'b0, 6'd63);
      send_reading(-9'sd120, 14'sd7000, 12'd0, 1'b1, 1'b1, 1'b0, 7'd70);
      settle_block();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: configure(1'b0, 1'b0, 6'($urandom_range(0, 63)));
            1: configure(1'b1, 1'b0, 6'd63);
            2: configure(1'b0, 1'b1, 6'd0);
            3: configure(1'b1, 1'b1, 6'd10);
            default: configure(1'b0, 1'b0, 6'd50);
         endcase
         run_random_phase(160);
         settle_block();
      end

      $display("Sent %0d laser readings in %0d scans; %0d scan decisions issued escape commands.",
               readings_sent, scans_sent, extrications);
      $display("Visited %0d register settings, covering both modes and the power extremes.",
               settings_used);
      if (mismatches == 0 && pending_commands == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
sv/pfes_pkg.sv
sv/pfes_front.sv
sv/pfes_queue.sv
sv/pfes_back.sv
sv/potential_field_escape_steering.sv
tb/escape_command_checker.sv
tb/potential_field_escape_steering_test.sv
